// ===== src/rspe_pkg.sv =====
package rspe_pkg;

    localparam int MAX_PARITY = 30;
    localparam int DEG_W      = $clog2(MAX_PARITY + 1);
    localparam int CNT_W      = 5;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = ADDR_W - 2;

    localparam logic [CNT_W-1:0] PARITY_COUNT_RST = CNT_W'(7);
    localparam logic [IDX_W-1:0] REG_PARITY_COUNT = IDX_W'(0);
    localparam logic [8:0]       GF_POLY          = 9'h11D;

    typedef logic [7:0] t_byte;

    function automatic t_byte gf_xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_xtime(sh);
        end
        return acc;
    endfunction

    function automatic logic [DEG_W-1:0] clamp_degree(input logic [CNT_W-1:0] v);
        if (int'(v) > MAX_PARITY) begin
            return DEG_W'(MAX_PARITY);
        end
        return DEG_W'(v);
    endfunction

endpackage

// ===== src/rspe_in_if.sv =====
interface rspe_in_if import rspe_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
    modport monitor (input valid, input data_byte, input last_byte, input ready);
endinterface

// ===== src/rspe_out_if.sv =====
interface rspe_out_if import rspe_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte parity_byte;
    logic  parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink (input valid, input parity_byte, input parity_last, output ready);
    modport monitor (input valid, input parity_byte, input parity_last, input ready);
endinterface

// ===== src/reed_solomon_parity_encoder_core.sv =====
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D, generator
// roots alpha^0 .. alpha^(d-1) as in QR codes. One data byte is taken per clock cycle while
// the input is ready; a parallel LFSR updates all d remainder bytes in the cycle the beat is
// accepted. On the beat flagged last the updated remainder is copied into an output shift
// register and drained as d parity beats, highest order first, one per cycle while the sink
// is ready, while the next message streams in; a further last beat waits only until the
// previous run is at its final parity beat. The parity count d (register 0, clamped to 30,
// reset value 7) rebuilds the generator one root per cycle; while that runs, after reset
// and after each write, the input is not ready. A write also discards any message in progress.
module reed_solomon_parity_encoder_core
    import rspe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    rspe_in_if.sink           i_in,
    rspe_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0] r_parity_count;
    logic [DEG_W-1:0] r_deg;
    logic [DEG_W-1:0] r_bld_left;
    logic [DEG_W-1:0] r_out_cnt;
    t_byte            r_root;
    t_byte            r_gen   [MAX_PARITY];
    t_byte            n_gen   [MAX_PARITY];
    t_byte            r_rem   [MAX_PARITY];
    t_byte            n_rem   [MAX_PARITY];
    t_byte            r_drain [MAX_PARITY];
    t_byte            n_drain [MAX_PARITY];
    t_byte            factor;
    logic             cfg_wr;
    logic             building;
    logic             load_ok;
    logic             in_fire;
    logic             out_fire;
    logic             load;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_PARITY_COUNT);
    assign prdata   = (paddr[ADDR_W-1:2] == REG_PARITY_COUNT)
                    ? DATA_W'(r_parity_count) : '0;

    assign building = (r_bld_left != '0);
    assign out_fire = o_out.valid && o_out.ready;
    assign load_ok  = (r_out_cnt == '0) || ((r_out_cnt == DEG_W'(1)) && o_out.ready);
    assign i_in.ready = !building && (!i_in.last_byte || load_ok);
    assign in_fire  = i_in.valid && i_in.ready;
    assign load     = in_fire && i_in.last_byte && (r_deg != '0);

    assign o_out.valid       = (r_out_cnt != '0);
    assign o_out.parity_byte = r_drain[0];
    assign o_out.parity_last = (r_out_cnt == DEG_W'(1));

    assign factor = i_in.data_byte ^ r_rem[0];

    // lfsr update, generator stored reversed so tap j pairs with remainder byte j
    always_comb begin
        for (int j = 0; j < MAX_PARITY - 1; j++) begin
            n_rem[j]   = r_rem[j+1] ^ gf_mul(r_gen[j], factor);
            n_drain[j] = r_drain[j+1];
        end
        n_rem[MAX_PARITY-1]   = gf_mul(r_gen[MAX_PARITY-1], factor);
        n_drain[MAX_PARITY-1] = '0;
    end

    // multiply reversed generator by (1 + root x)
    always_comb begin
        n_gen[0] = r_gen[0] ^ r_root;
        for (int j = 1; j < MAX_PARITY; j++) begin
            n_gen[j] = r_gen[j] ^ gf_mul(r_root, r_gen[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_count <= PARITY_COUNT_RST;
            r_deg          <= clamp_degree(PARITY_COUNT_RST);
            r_bld_left     <= clamp_degree(PARITY_COUNT_RST);
            r_root         <= 8'h01;
            r_gen          <= '{default: '0};
            r_rem          <= '{default: '0};
        end else if (cfg_wr) begin
            r_parity_count <= pwdata[CNT_W-1:0];
            r_deg          <= clamp_degree(pwdata[CNT_W-1:0]);
            r_bld_left     <= clamp_degree(pwdata[CNT_W-1:0]);
            r_root         <= 8'h01;
            r_gen          <= '{default: '0};
            r_rem          <= '{default: '0};
        end else if (building) begin
            r_gen      <= n_gen;
            r_root     <= gf_xtime(r_root);
            r_bld_left <= r_bld_left - DEG_W'(1);
        end else if (in_fire) begin
            if (i_in.last_byte) begin
                r_rem <= '{default: '0};
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= '0;
        end else if (load) begin
            r_out_cnt <= r_deg;
        end else if (out_fire) begin
            r_out_cnt <= r_out_cnt - DEG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_drain <= n_rem;
        end else if (out_fire) begin
            r_drain <= n_drain;
        end
    end

endmodule

// ===== src/rspe_checker.sv =====
module rspe_checker
    import rspe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_byte             i_out_byte,
    input logic              i_out_last,
    input logic              i_psel,
    input logic              i_penable,
    input logic              i_pwrite,
    input logic [ADDR_W-1:0] i_paddr,
    input logic [DATA_W-1:0] i_pwdata
);

    // stalled parity beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("parity beat changed while stalled");

    // nonzero parity count rebuilds the generator and holds off input
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[ADDR_W-1:2] == REG_PARITY_COUNT)
            && (i_pwdata[CNT_W-1:0] != '0) |=> !i_in_ready)
        else $error("input ready during generator rebuild");

    // a last beat only enters when the previous run is at its final beat
    a_last_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last && i_out_valid |->
            i_out_ready && i_out_last)
        else $error("last beat accepted while parity still pending");

    // run ends after its final beat unless a new one is loaded
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last
            && !(i_in_valid && i_in_ready && i_in_last) |=> !i_out_valid)
        else $error("parity beat after final beat");

endmodule

bind reed_solomon_parity_encoder_core rspe_checker u_rspe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.parity_byte),
    .i_out_last  (o_out.parity_last),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata)
);

// ===== sim/reed_solomon_parity_encoder_core_test.sv =====
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_core_test;
    import rspe_pkg::*;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_msg_beat;

    typedef struct packed {
        t_byte parity;
        logic  fin;
    } t_parity_beat;

    localparam logic [ADDR_W-1:0] PARITY_COUNT_ADDR = {REG_PARITY_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR     = ADDR_W'(4);
    localparam int                RANDOM_BEATS      = 210;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rspe_in_if  data_ch ();
    rspe_out_if parity_ch ();

    reed_solomon_parity_encoder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (data_ch),
        .o_out   (parity_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // encoder state mirror
    logic [CNT_W-1:0] parity_count_q;
    t_byte            remainder_q [MAX_PARITY];
    t_byte            gen_coeff   [MAX_PARITY];

    t_msg_beat    pending_beats [$];
    t_parity_beat parity_expect [$];
    t_parity_beat parity_head;

    int unsigned queued_beats     = 0;
    int unsigned accepted_beats   = 0;
    int unsigned message_cnt      = 0;
    int unsigned parity_seen      = 0;
    int unsigned settings_applied = 0;
    int unsigned fail_cnt         = 0;
    int unsigned send_gap         = 0;
    int unsigned stall_left       = 0;
    int unsigned hold_left        = 0;
    bit          steady_src       = 1'b0;
    bit          steady_sink      = 1'b0;

    always #6 i_clk = ~i_clk;

    function automatic t_byte gf_product(input t_byte a, input t_byte b);
        logic [8:0] sh;
        t_byte      acc;
        acc = '0;
        sh  = {1'b0, a};
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc ^= sh[7:0];
            end
            sh = sh << 1;
            if (sh[8]) begin
                sh ^= GF_POLY;
            end
        end
        return acc;
    endfunction

    function automatic int active_deg();
        return (int'(parity_count_q) > MAX_PARITY) ? MAX_PARITY : int'(parity_count_q);
    endfunction

    // product of (x - alpha^i), i = 0 .. d-1, leading term dropped
    function automatic void rebuild_generator();
        t_byte poly [MAX_PARITY+1];
        t_byte root;
        int    d;
        d = active_deg();
        foreach (poly[k]) begin
            poly[k] = '0;
        end
        poly[0] = 8'h01;
        root    = 8'h01;
        for (int i = 0; i < d; i++) begin
            for (int j = i + 1; j > 0; j--) begin
                poly[j] = poly[j-1] ^ gf_product(poly[j], root);
            end
            poly[0] = gf_product(poly[0], root);
            root    = gf_product(root, 8'h02);
        end
        for (int i = 0; i < MAX_PARITY; i++) begin
            gen_coeff[i] = (i < d) ? poly[i] : 8'h00;
        end
        foreach (remainder_q[k]) begin
            remainder_q[k] = '0;
        end
    endfunction

    function automatic void absorb_byte(input t_byte data, input logic last);
        int    d;
        t_byte factor;
        d = active_deg();
        if (d > 0) begin
            factor = data ^ remainder_q[0];
            for (int j = 0; j + 1 < d; j++) begin
                remainder_q[j] = remainder_q[j+1];
            end
            remainder_q[d-1] = '0;
            for (int j = 0; j < d; j++) begin
                remainder_q[j] ^= gf_product(gen_coeff[d-1-j], factor);
            end
        end
        if (last) begin
            for (int j = 0; j < d; j++) begin
                parity_expect.push_back('{parity: remainder_q[j], fin: (j + 1 == d)});
            end
            foreach (remainder_q[k]) begin
                remainder_q[k] = '0;
            end
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_beat(input t_byte data, input logic last);
        pending_beats.push_back('{data: data, last: last});
        queued_beats++;
        if (last) begin
            message_cnt++;
        end
    endfunction

    task automatic push_message(input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            push_beat(t_byte'($urandom()), k + 1 == len);
        end
    endtask

    task automatic wait_idle();
        while (accepted_beats != queued_beats || parity_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_count_readback();
        logic [DATA_W-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PARITY_COUNT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CNT_W-1:0] !== parity_count_q) begin
            $error("parity_count expected %0d actual %0d", parity_count_q, rd[CNT_W-1:0]);
            fail_cnt++;
        end
    endtask

    task automatic apply_count(input int unsigned value);
        apb_write(PARITY_COUNT_ADDR, DATA_W'(value));
        parity_count_q = CNT_W'(value);
        rebuild_generator();
        settings_applied++;
        check_count_readback();
    endtask

    // data driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            data_ch.valid <= 1'b0;
        end else begin
            if (data_ch.valid && data_ch.ready) begin
                absorb_byte(data_ch.data_byte, data_ch.last_byte);
                accepted_beats++;
            end
            if (!data_ch.valid || data_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    data_ch.valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    data_ch.valid     <= 1'b1;
                    data_ch.data_byte <= pending_beats[0].data;
                    data_ch.last_byte <= pending_beats[0].last;
                    void'(pending_beats.pop_front());
                    send_gap = steady_src ? 0 : pick_gap();
                end else begin
                    data_ch.valid <= 1'b0;
                end
            end
        end
    end

    // parity sink backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parity_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            parity_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            parity_ch.ready <= 1'b0;
        end else begin
            parity_ch.ready <= 1'b1;
            stall_left = steady_sink ? 0 : pick_gap();
        end
    end

    // parity monitor
    always @(posedge i_clk) begin
        if (i_rst_n && parity_ch.valid && parity_ch.ready) begin
            parity_seen++;
            if (parity_expect.size() == 0) begin
                $error("parity beat %02h with nothing expected", parity_ch.parity_byte);
                fail_cnt++;
            end else begin
                parity_head = parity_expect.pop_front();
                if (parity_ch.parity_byte !== parity_head.parity) begin
                    $error("parity_byte expected %02h actual %02h",
                           parity_head.parity, parity_ch.parity_byte);
                    fail_cnt++;
                end
                if (parity_ch.parity_last !== parity_head.fin) begin
                    $error("parity_last expected %0b actual %0b",
                           parity_head.fin, parity_ch.parity_last);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("reed_solomon_parity_encoder_core_test failed");
        $finish;
    end

    initial begin
        int unsigned random_base;
        int unsigned phase_beats;
        int unsigned len;
        int unsigned ph;
        i_rst_n           = 1'b0;
        data_ch.valid     = 1'b0;
        data_ch.data_byte = '0;
        data_ch.last_byte = 1'b0;
        parity_ch.ready   = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        parity_count_q    = PARITY_COUNT_RST;
        rebuild_generator();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count, single-byte and short messages
        push_beat(8'h00, 1'b1);
        push_beat(8'hFF, 1'b1);
        push_beat(8'h01, 1'b0);
        push_beat(8'h80, 1'b0);
        push_beat(8'h55, 1'b1);
        wait_idle();
        check_count_readback();

        // zero count gives no parity
        apply_count(0);
        push_beat(8'hA5, 1'b0);
        push_beat(8'h5A, 1'b1);
        wait_idle();

        apply_count(1);
        push_beat(8'h7F, 1'b0);
        push_beat(8'hFE, 1'b1);
        wait_idle();

        // above maximum, clamped
        apply_count(31);
        push_beat(8'hC3, 1'b0);
        push_beat(8'h3C, 1'b1);
        wait_idle();

        // write drops a message in progress
        apply_count(2);
        push_beat(8'h11, 1'b0);
        push_beat(8'h22, 1'b0);
        push_beat(8'h33, 1'b0);
        wait_idle();
        apply_count(2);
        push_beat(8'h44, 1'b0);
        push_beat(8'h99, 1'b1);
        wait_idle();

        // unmapped address leaves everything alone
        push_beat(8'hE7, 1'b0);
        push_beat(8'h18, 1'b0);
        wait_idle();
        apb_write(UNMAPPED_ADDR, DATA_W'($urandom()));
        check_count_readback();
        push_beat(8'h10, 1'b1);
        wait_idle();

        // parity side held off while short messages pile up
        apply_count(30);
        steady_src = 1'b1;
        hold_left  = 300;
        for (int k = 0; k < 12; k++) begin
            push_message($urandom_range(1, 3));
        end
        wait_idle();
        steady_src = 1'b0;

        random_base = queued_beats;
        ph          = 0;
        while (queued_beats - random_base < RANDOM_BEATS) begin
            wait_idle();
            if (ph == 0) begin
                apply_count(2);
            end else if (ph == 1) begin
                apply_count(30);
            end else begin
                apply_count($urandom_range(0, 31));
            end
            steady_src  = ($urandom_range(0, 3) == 0);
            steady_sink = ($urandom_range(0, 3) == 0);
            phase_beats = 0;
            while (phase_beats < 40 && queued_beats - random_base < RANDOM_BEATS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
                push_message(len);
                phase_beats += len;
                if ($urandom_range(0, 5) == 0) begin
                    wait_idle();
                end
            end
            ph++;
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        $display("covered %0d data beats in %0d messages over %0d parity-count settings",
                 accepted_beats, message_cnt, settings_applied);
        $display("checked %0d parity beats, %0d failures", parity_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("reed_solomon_parity_encoder_core_test passed");
        end else begin
            $display("reed_solomon_parity_encoder_core_test failed");
        end
        $finish;
    end

endmodule
